// ----- sv/srrw_pkg.sv -----
// ============================================================================
// srrw_pkg
// Shared types and constants for the selective-repeat receive window.
// ============================================================================
package srrw_pkg;

    // Field widths fixed by the interface.
    localparam int SEQ_FIELD_W   = 32;
    localparam int WIN_CFG_W     = 5;
    localparam int WIN_CFG_RESET = 8;

    // Defaults for the top-level parameters.
    localparam int WINDOW_MAX_DEF = 16;
    localparam int SEQ_WIDTH_DEF  = 32;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        KIND_DISCARD = 3'd0,
        KIND_ACK     = 3'd1,
        KIND_DELIVER = 3'd2,
        KIND_BUFFER  = 3'd3,
        KIND_RELEASE = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ECHO_NONE = 2'd0,
        ECHO_SYN  = 2'd1,
        ECHO_FIN  = 2'd2,
        ECHO_PING = 2'd3
    } echo_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_SEQ,
        ST_MOD_NXT,
        ST_SCAN,
        ST_HEAD,
        ST_REL
    } back_state_t;

    typedef struct packed {
        logic [SEQ_FIELD_W-1:0] seq_num;
        logic                   checksum_ok;
        logic                   flag_syn;
        logic                   flag_fin;
        logic                   flag_ping;
    } in_item_t;

    typedef struct packed {
        kind_t                  kind;
        logic [SEQ_FIELD_W-1:0] out_seq;
        logic                   send_ack;
        echo_t                  ack_echo;
        logic                   complete;
        logic                   last_of_run;
    } out_item_t;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        logic [SEQ_FIELD_W-1:0] seq;
        logic                   bad;
        logic                   ack_only;
        logic                   fin;
        echo_t                  echo;
    } desc_t;

endpackage

// ----- sv/srrw_front.sv -----
// ============================================================================
// srrw_front
// Classifies an arriving header: masks the sequence number, flags damage,
// marks SYN/PING requests as acknowledge-only and works out the echo flag.
// ============================================================================
module srrw_front #(
    parameter int SEQ_WIDTH = srrw_pkg::SEQ_WIDTH_DEF
) (
    input  srrw_pkg::in_item_t item_i,
    output srrw_pkg::desc_t    desc_o
);

    localparam logic [srrw_pkg::SEQ_FIELD_W-1:0] SEQ_MASK =
        srrw_pkg::SEQ_FIELD_W'((33'd1 << SEQ_WIDTH) - 33'd1);

    srrw_pkg::echo_t echo;

    // Echo priority: SYN without PING, then FIN, then PING.
    always_comb begin
        priority if (item_i.flag_syn && !item_i.flag_ping) begin
            echo = srrw_pkg::ECHO_SYN;
        end else if (item_i.flag_fin) begin
            echo = srrw_pkg::ECHO_FIN;
        end else if (item_i.flag_ping) begin
            echo = srrw_pkg::ECHO_PING;
        end else begin
            echo = srrw_pkg::ECHO_NONE;
        end
    end

    assign desc_o.seq      = item_i.seq_num & SEQ_MASK;
    assign desc_o.bad      = !item_i.checksum_ok;
    assign desc_o.ack_only = item_i.flag_syn || item_i.flag_ping;
    assign desc_o.fin      = item_i.flag_fin;
    assign desc_o.echo     = echo;

endmodule

// ----- sv/srrw_queue.sv -----
// ============================================================================
// srrw_queue
// Short request queue between the front and back parts.
// ============================================================================
module srrw_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_i,
    input  srrw_pkg::desc_t  push_data_i,
    output logic             full_o,
    input  logic             pop_i,
    output logic             valid_o,
    output srrw_pkg::desc_t  data_o
);

    localparam int DEPTH = srrw_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    srrw_pkg::desc_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full_o  = (count_reg == CW'(DEPTH));
    assign valid_o = (count_reg != '0);
    assign data_o  = mem_reg[rd_ptr_reg];
    assign do_push = push_i && !full_o;
    assign do_pop  = pop_i && valid_o;

    // Pointer and fill-count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data_i;
        end
    end

endmodule

// ----- sv/srrw_back.sv -----
// ============================================================================
// srrw_back
// Window state, slot store, serial modulo unit, release scan and the
// result register.
// ============================================================================
module srrw_back #(
    parameter int WINDOW_MAX = srrw_pkg::WINDOW_MAX_DEF,
    parameter int SEQ_WIDTH  = srrw_pkg::SEQ_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [srrw_pkg::WIN_CFG_W-1:0]     window_size_i,
    input  logic                               q_valid_i,
    input  srrw_pkg::desc_t                    q_data_i,
    output logic                               q_pop_o,
    output logic                               m_valid_o,
    input  logic                               m_ready_i,
    output srrw_pkg::out_item_t                m_data_o
);

    localparam int SW   = SEQ_WIDTH;
    localparam int WW   = $clog2(WINDOW_MAX + 1);
    localparam int IW   = $clog2(WINDOW_MAX);
    localparam int BW   = $clog2(SW);
    localparam int CFW  = srrw_pkg::WIN_CFG_W;
    localparam int CMPW = (WW > CFW) ? WW : CFW;

    // Effective window: zero used as one, clipped to the maximum.
    logic [CMPW-1:0] cfg_wide;
    logic [WW-1:0]   w_eff;

    assign cfg_wide = CMPW'(window_size_i);

    always_comb begin
        priority if (cfg_wide == '0) begin
            w_eff = WW'(1);
        end else if (cfg_wide > CMPW'(WINDOW_MAX)) begin
            w_eff = WW'(WINDOW_MAX);
        end else begin
            w_eff = WW'(cfg_wide);
        end
    end

    srrw_pkg::back_state_t state_reg, state_next;

    logic [SW-1:0]     lio_reg, lio_next;
    logic [SW-1:0]     final_reg, final_next;
    logic              fin_seen_reg, fin_seen_next;
    logic [SW-1:0]     slot_seq_reg [WINDOW_MAX];
    logic              slot_rcv_reg [WINDOW_MAX];
    logic              slot_we;
    logic [IW-1:0]     slot_wi;

    srrw_pkg::desc_t   item_reg, item_next;
    srrw_pkg::kind_t   head_kind_reg, head_kind_next;
    logic [SW-1:0]     base_reg, base_next;
    logic [SW-1:0]     mod_op_reg, mod_op_next;
    logic [WW-1:0]     rem_reg, rem_next;
    logic [BW-1:0]     bcnt_reg, bcnt_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [WW-1:0]     r_reg, r_next;
    logic [WW-1:0]     nrel_reg, nrel_next;
    logic [WW-1:0]     rk_reg, rk_next;

    logic                 m_valid_reg, m_valid_next;
    srrw_pkg::out_item_t  m_data_reg, m_data_next;

    logic [SW-1:0]   seq;
    logic [WW:0]     shifted;
    logic [WW-1:0]   rem_step;
    logic [IW-1:0]   rem_idx;
    logic [IW-1:0]   rem_idx_adv;
    logic [IW-1:0]   idx_adv;
    logic [SW-1:0]   lio_inc;
    logic            beyond;
    logic            can_push;
    logic            complete;
    logic            slot_hit;

    assign seq      = item_reg.seq[SW-1:0];
    assign lio_inc  = lio_reg + 1'b1;
    assign can_push = !m_valid_reg || m_ready_i;
    assign complete = fin_seen_reg && (lio_reg == final_reg);

    // Right of the window: seq > last_in_order + window, without overflow.
    assign beyond = ((SW + 1)'(q_data_i.seq[SW-1:0]) >
                     ((SW + 1)'(lio_reg) + (SW + 1)'(w_eff)));

    // One restoring step of the serial modulo unit.
    assign shifted  = {rem_reg, mod_op_reg[bcnt_reg]};
    assign rem_step = (shifted >= {1'b0, w_eff}) ? WW'(shifted - {1'b0, w_eff})
                                                  : WW'(shifted);
    assign rem_idx     = rem_step[IW-1:0];
    assign rem_idx_adv = ((WW'(rem_idx) + 1'b1) == w_eff) ? '0 : rem_idx + 1'b1;
    assign idx_adv     = ((WW'(idx_reg) + 1'b1) == w_eff) ? '0 : idx_reg + 1'b1;

    // Slot match for the release scan.
    assign slot_hit = (r_reg < w_eff) && (lio_reg != '1) && slot_rcv_reg[idx_reg]
                      && (slot_seq_reg[idx_reg] == lio_inc);

    // Next state, datapath updates and result pushes.
    always_comb begin
        state_next     = state_reg;
        lio_next       = lio_reg;
        final_next     = final_reg;
        fin_seen_next  = fin_seen_reg;
        item_next      = item_reg;
        head_kind_next = head_kind_reg;
        base_next      = base_reg;
        mod_op_next    = mod_op_reg;
        rem_next       = rem_reg;
        bcnt_next      = bcnt_reg;
        idx_next       = idx_reg;
        r_next         = r_reg;
        nrel_next      = nrel_reg;
        rk_next        = rk_reg;
        slot_we        = 1'b0;
        slot_wi        = rem_idx;
        q_pop_o        = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready_i;
        m_data_next    = m_data_reg;

        unique case (state_reg)
            // Take a request and settle the cases that need no slot work.
            srrw_pkg::ST_IDLE: begin
                if (q_valid_i) begin
                    q_pop_o   = 1'b1;
                    item_next = q_data_i;
                    nrel_next = '0;
                    priority if (q_data_i.bad || beyond) begin
                        head_kind_next = srrw_pkg::KIND_DISCARD;
                        state_next     = srrw_pkg::ST_HEAD;
                    end else if (q_data_i.ack_only || (q_data_i.seq[SW-1:0] <= lio_reg)) begin
                        head_kind_next = srrw_pkg::KIND_ACK;
                        state_next     = srrw_pkg::ST_HEAD;
                    end else begin
                        if (q_data_i.fin) begin
                            final_next    = q_data_i.seq[SW-1:0];
                            fin_seen_next = 1'b1;
                        end
                        mod_op_next = q_data_i.seq[SW-1:0];
                        rem_next    = '0;
                        bcnt_next   = BW'(SW - 1);
                        state_next  = srrw_pkg::ST_MOD_SEQ;
                    end
                end
            end
            // Slot of the arriving number; then deliver or buffer.
            srrw_pkg::ST_MOD_SEQ: begin
                rem_next  = rem_step;
                bcnt_next = bcnt_reg - 1'b1;
                if (bcnt_reg == '0) begin
                    r_next = WW'(1);
                    if (seq == lio_inc) begin
                        lio_next       = seq;
                        base_next      = seq;
                        idx_next       = rem_idx_adv;
                        head_kind_next = srrw_pkg::KIND_DELIVER;
                        state_next     = srrw_pkg::ST_SCAN;
                    end else begin
                        slot_we        = 1'b1;
                        head_kind_next = srrw_pkg::KIND_BUFFER;
                        mod_op_next    = lio_inc;
                        rem_next       = '0;
                        bcnt_next      = BW'(SW - 1);
                        state_next     = srrw_pkg::ST_MOD_NXT;
                    end
                end
            end
            // Slot of the next in-order number.
            srrw_pkg::ST_MOD_NXT: begin
                rem_next  = rem_step;
                bcnt_next = bcnt_reg - 1'b1;
                if (bcnt_reg == '0) begin
                    idx_next   = rem_idx;
                    base_next  = lio_reg;
                    state_next = srrw_pkg::ST_SCAN;
                end
            end
            // Release scan, one slot a cycle.
            srrw_pkg::ST_SCAN: begin
                if (slot_hit) begin
                    lio_next  = lio_inc;
                    nrel_next = nrel_reg + 1'b1;
                    r_next    = r_reg + 1'b1;
                    idx_next  = idx_adv;
                end else begin
                    state_next = srrw_pkg::ST_HEAD;
                end
            end
            // First result of the request.
            srrw_pkg::ST_HEAD: begin
                if (can_push) begin
                    m_valid_next         = 1'b1;
                    m_data_next.kind     = head_kind_reg;
                    m_data_next.out_seq  = srrw_pkg::SEQ_FIELD_W'(seq);
                    m_data_next.send_ack = (head_kind_reg != srrw_pkg::KIND_DISCARD);
                    m_data_next.ack_echo = (head_kind_reg == srrw_pkg::KIND_DISCARD)
                                           ? srrw_pkg::ECHO_NONE : item_reg.echo;
                    m_data_next.complete    = complete;
                    m_data_next.last_of_run = (nrel_reg == '0);
                    rk_next    = WW'(1);
                    state_next = (nrel_reg == '0) ? srrw_pkg::ST_IDLE : srrw_pkg::ST_REL;
                end
            end
            // Released numbers follow in order.
            srrw_pkg::ST_REL: begin
                if (can_push) begin
                    m_valid_next            = 1'b1;
                    m_data_next.kind        = srrw_pkg::KIND_RELEASE;
                    m_data_next.out_seq     = srrw_pkg::SEQ_FIELD_W'(base_reg + SW'(rk_reg));
                    m_data_next.send_ack    = 1'b0;
                    m_data_next.ack_echo    = srrw_pkg::ECHO_NONE;
                    m_data_next.complete    = complete;
                    m_data_next.last_of_run = (rk_reg == nrel_reg);
                    rk_next = rk_reg + 1'b1;
                    if (rk_reg == nrel_reg) begin
                        state_next = srrw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = srrw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= srrw_pkg::ST_IDLE;
            lio_reg      <= '0;
            final_reg    <= '0;
            fin_seen_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            lio_reg      <= lio_next;
            final_reg    <= final_next;
            fin_seen_reg <= fin_seen_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Working registers and the result payload.
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        head_kind_reg <= head_kind_next;
        base_reg      <= base_next;
        mod_op_reg    <= mod_op_next;
        rem_reg       <= rem_next;
        bcnt_reg      <= bcnt_next;
        idx_reg       <= idx_next;
        r_reg         <= r_next;
        nrel_reg      <= nrel_next;
        rk_reg        <= rk_next;
        m_data_reg    <= m_data_next;
    end

    // Slot store: received marks are cleared by reset, numbers are payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_MAX; i++) begin
                slot_rcv_reg[i] <= 1'b0;
            end
        end else if (slot_we) begin
            slot_rcv_reg[slot_wi] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_seq_reg[slot_wi] <= seq;
        end
    end

    assign m_valid_o = m_valid_reg;
    assign m_data_o  = m_data_reg;

endmodule

// ----- sv/selective_repeat_receive_window_top.sv -----
// ============================================================================
// selective_repeat_receive_window_top
// Receiver half of a selective-repeat window: classifies packet headers,
// delivers or buffers them and releases runs of buffered successors.
// ============================================================================
//
//  Channel   Ports                          Direction  Payload
//  --------  -----------------------------  ---------  --------------------
//  input     s_valid, s_ready, s_data       in         srrw_pkg::in_item_t
//  result    m_valid, m_ready, m_data       out        srrw_pkg::out_item_t
//  config    cfg_wr_en, cfg_wr_data         in         window_size, 5 bits
//
//  A discarded or acknowledge-only request goes from idle straight to its
//  registered head result. A delivered request passes the bit-serial modulo
//  unit once and a buffered one twice, then the release scan runs and the
//  results follow, one per cycle while the result register is not stalled.
//  Reset is synchronous and active low; it clears the window and all slot marks.
//  A stalled result register holds the back part, while the queue keeps
//  taking requests until it is full.
//
module selective_repeat_receive_window_top #(
    parameter int WINDOW_MAX = srrw_pkg::WINDOW_MAX_DEF,
    parameter int SEQ_WIDTH  = srrw_pkg::SEQ_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  srrw_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output srrw_pkg::out_item_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [srrw_pkg::WIN_CFG_W-1:0]  cfg_wr_data
);

    logic [srrw_pkg::WIN_CFG_W-1:0] window_size_reg;
    srrw_pkg::desc_t                front_desc;
    srrw_pkg::desc_t                q_data;
    logic                           q_full;
    logic                           q_valid;
    logic                           q_pop;

    // Window size register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= srrw_pkg::WIN_CFG_W'(srrw_pkg::WIN_CFG_RESET);
        end else if (cfg_wr_en) begin
            window_size_reg <= cfg_wr_data;
        end
    end

    srrw_front #(
        .SEQ_WIDTH (SEQ_WIDTH)
    ) u_front (
        .item_i (s_data),
        .desc_o (front_desc)
    );

    assign s_ready = !q_full;

    srrw_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (s_valid),
        .push_data_i (front_desc),
        .full_o      (q_full),
        .pop_i       (q_pop),
        .valid_o     (q_valid),
        .data_o      (q_data)
    );

    srrw_back #(
        .WINDOW_MAX (WINDOW_MAX),
        .SEQ_WIDTH  (SEQ_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .window_size_i (window_size_reg),
        .q_valid_i     (q_valid),
        .q_data_i      (q_data),
        .q_pop_o       (q_pop),
        .m_valid_o     (m_valid),
        .m_ready_i     (m_ready),
        .m_data_o      (m_data)
    );

endmodule

// ----- sv/srrw_checker.sv -----
// ============================================================================
// srrw_checker
// Port-level checks on the result channel of the receive window.
// ============================================================================
module srrw_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input srrw_pkg::out_item_t m_data
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // A discard is alone and sends no acknowledgment.
    a_discard: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == srrw_pkg::KIND_DISCARD)
        |-> m_data.last_of_run && !m_data.send_ack)
        else $error("discard malformed");

    // Releases carry no acknowledgment and no echo.
    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == srrw_pkg::KIND_RELEASE)
        |-> !m_data.send_ack && (m_data.ack_echo == srrw_pkg::ECHO_NONE))
        else $error("release malformed");

    // A release follows, once taken, a result of the same request.
    a_release_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_of_run ##1 m_valid
        |-> (m_data.kind == srrw_pkg::KIND_RELEASE))
        else $error("result after open run is not a release");

endmodule

bind selective_repeat_receive_window_top srrw_checker u_srrw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
